// File: rtl/gcs_pkg.sv
package gcs_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned ForceW     = 16;
  localparam int unsigned PosW       = 16;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned FifoDepth  = 8;
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);
  localparam int unsigned SlotCntW   = $clog2(MaxResults + 1);

  localparam logic [CfgIdxW-1:0] CfgContactThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinStanceTime    = 1'b1;

  localparam logic [ForceW-1:0] ContactThresholdRst = 16'd410;
  localparam logic [TimeW-1:0]  MinStanceTimeRst    = 32'd100000;

  localparam logic LegLeft  = 1'b0;
  localparam logic LegRight = 1'b1;

  typedef enum logic [1:0] {
    PhSeekFlight = 2'd0,
    PhSeekTouch  = 2'd1,
    PhStance     = 2'd2,
    PhSwing      = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TimeW-1:0]        frame_time;
    logic [ForceW-1:0]       grf_left;
    logic [ForceW-1:0]       grf_right;
    logic signed [PosW-1:0]  cop_left_x;
    logic signed [PosW-1:0]  cop_left_y;
    logic signed [PosW-1:0]  cop_left_z;
    logic signed [PosW-1:0]  cop_right_x;
    logic signed [PosW-1:0]  cop_right_y;
    logic signed [PosW-1:0]  cop_right_z;
    logic                    final_frame;
  } in_t;

  typedef struct packed {
    logic                    leg_side;
    logic [TimeW-1:0]        stance_start;
    logic [TimeW-1:0]        swing_start;
    logic [TimeW-1:0]        cycle_end;
    logic signed [PosW-1:0]  start_x;
    logic signed [PosW-1:0]  start_y;
    logic signed [PosW-1:0]  start_z;
    logic signed [PosW-1:0]  end_x;
    logic signed [PosW-1:0]  end_y;
    logic signed [PosW-1:0]  end_z;
    logic                    last_of_run;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0]        stance_start;
    logic [TimeW-1:0]        swing_start;
    logic [TimeW-1:0]        cycle_end;
    logic signed [PosW-1:0]  start_x;
    logic signed [PosW-1:0]  start_y;
    logic signed [PosW-1:0]  start_z;
    logic signed [PosW-1:0]  end_x;
    logic signed [PosW-1:0]  end_y;
    logic signed [PosW-1:0]  end_z;
  } cycle_t;

  typedef struct packed {
    logic   rel_valid;
    cycle_t rel;
    logic   flush_valid;
    cycle_t flush;
  } lane_res_t;

  typedef struct packed {
    logic [TimeW-1:0] frame_time;
    logic [ForceW-1:0] grf;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic final_frame;
  } lane_in_t;

endpackage

// File: rtl/gait_cycle_segmenter.sv
// Gait cycle segmenter: takes one frame per clock cycle when not stalled and runs a
// force-threshold tracker for each leg in parallel; a frame is handled in the cycle
// it transfers. Each frame yields zero to four stride records (left before right),
// which enter an eight-entry result queue and leave one per cycle when not stalled;
// a frame's results are registered before they appear. The input stalls while
// more than four results are queued, so the sustained frame rate is one per cycle
// as long as frames average at most one result and the output side keeps up.
// Configuration writes are taken at any time but must only be issued while idle.
module gait_cycle_segmenter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gcs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [gcs_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  gcs_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output gcs_pkg::out_t                      out_data_o
);

  logic [gcs_pkg::ForceW-1:0]      threshold_q;
  logic [gcs_pkg::TimeW-1:0]       stance_min_q;
  logic                            accept;
  logic                            full;
  gcs_pkg::lane_in_t               left_in, right_in;
  gcs_pkg::lane_res_t              left_res, right_res;
  gcs_pkg::out_t                   slot [gcs_pkg::MaxResults];
  logic [gcs_pkg::SlotCntW-1:0]    push_n;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= gcs_pkg::ContactThresholdRst;
      stance_min_q <= gcs_pkg::MinStanceTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gcs_pkg::CfgContactThreshold: threshold_q  <= cfg_data_i[gcs_pkg::ForceW-1:0];
        gcs_pkg::CfgMinStanceTime:    stance_min_q <= cfg_data_i[gcs_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    left_in.frame_time   = in_data_i.frame_time;
    left_in.grf          = in_data_i.grf_left;
    left_in.pos_x        = in_data_i.cop_left_x;
    left_in.pos_y        = in_data_i.cop_left_y;
    left_in.pos_z        = in_data_i.cop_left_z;
    left_in.final_frame  = in_data_i.final_frame;
    right_in.frame_time  = in_data_i.frame_time;
    right_in.grf         = in_data_i.grf_right;
    right_in.pos_x       = in_data_i.cop_right_x;
    right_in.pos_y       = in_data_i.cop_right_y;
    right_in.pos_z       = in_data_i.cop_right_z;
    right_in.final_frame = in_data_i.final_frame;
  end

  gcs_lane u_lane_left (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_i      (left_in),
    .threshold_i  (threshold_q),
    .stance_min_i (stance_min_q),
    .res_o        (left_res)
  );

  gcs_lane u_lane_right (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_i      (right_in),
    .threshold_i  (threshold_q),
    .stance_min_i (stance_min_q),
    .res_o        (right_res)
  );

  gcs_merge u_merge (
    .left_i  (left_res),
    .right_i (right_res),
    .slot_o  (slot),
    .count_o (push_n)
  );

  gcs_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slot_i   (slot),
    .push_n_i (push_n),
    .pop_i    (out_valid_o && !out_stall_i),
    .full_o   (full),
    .valid_o  (out_valid_o),
    .data_o   (out_data_o)
  );

endmodule

// File: rtl/gcs_lane.sv
module gcs_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  gcs_pkg::lane_in_t                  frame_i,
  input  logic [gcs_pkg::ForceW-1:0]         threshold_i,
  input  logic [gcs_pkg::TimeW-1:0]          stance_min_i,
  output gcs_pkg::lane_res_t                 res_o
);

  gcs_pkg::phase_e               phase_q, phase_d;
  logic                          pv_q, pv_d;
  logic [gcs_pkg::TimeW-1:0]     open_start_q, open_start_d;
  logic [gcs_pkg::TimeW-1:0]     open_swing_q, open_swing_d;
  logic signed [gcs_pkg::PosW-1:0] open_x_q, open_y_q, open_z_q;
  logic signed [gcs_pkg::PosW-1:0] open_x_d, open_y_d, open_z_d;
  gcs_pkg::cycle_t               pend_q, pend_d;
  logic                          contact;
  logic                          complete;
  logic                          bump;
  logic [gcs_pkg::TimeW-1:0]     stance;

  assign contact  = frame_i.grf >= threshold_i;
  assign stance   = open_swing_q - open_start_q;
  assign bump     = stance < stance_min_i;
  assign complete = (phase_q == gcs_pkg::PhSwing) && contact;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      gcs_pkg::PhSeekFlight: begin
        if (!contact) phase_d = gcs_pkg::PhSeekTouch;
      end
      gcs_pkg::PhSeekTouch: begin
        if (contact) phase_d = gcs_pkg::PhStance;
      end
      gcs_pkg::PhStance: begin
        if (!contact) phase_d = gcs_pkg::PhSwing;
      end
      gcs_pkg::PhSwing: begin
        if (contact) phase_d = gcs_pkg::PhStance;
      end
      default: phase_d = gcs_pkg::PhSeekFlight;
    endcase
    if (frame_i.final_frame) phase_d = gcs_pkg::PhSeekFlight;
  end

  always_comb begin
    pv_d         = pv_q;
    open_start_d = open_start_q;
    open_swing_d = open_swing_q;
    open_x_d     = open_x_q;
    open_y_d     = open_y_q;
    open_z_d     = open_z_q;
    pend_d       = pend_q;
    if ((phase_q == gcs_pkg::PhSeekTouch && contact) || complete) begin
      open_start_d = frame_i.frame_time;
      open_x_d     = frame_i.pos_x;
      open_y_d     = frame_i.pos_y;
      open_z_d     = frame_i.pos_z;
    end
    if (phase_q == gcs_pkg::PhStance && !contact) begin
      open_swing_d = frame_i.frame_time;
    end
    if (complete && (!bump || pv_q)) begin
      pend_d.cycle_end = frame_i.frame_time;
      pend_d.end_x     = frame_i.pos_x;
      pend_d.end_y     = frame_i.pos_y;
      pend_d.end_z     = frame_i.pos_z;
      if (!bump) begin
        pv_d                = 1'b1;
        pend_d.stance_start = open_start_q;
        pend_d.swing_start  = open_swing_q;
        pend_d.start_x      = open_x_q;
        pend_d.start_y      = open_y_q;
        pend_d.start_z      = open_z_q;
      end
    end
  end

  always_comb begin
    res_o.rel_valid   = accept_i && complete && !bump && pv_q;
    res_o.rel         = pend_q;
    res_o.flush_valid = accept_i && frame_i.final_frame && pv_d;
    res_o.flush       = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gcs_pkg::PhSeekFlight;
      pv_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pv_q    <= pv_d && !frame_i.final_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      open_start_q <= open_start_d;
      open_swing_q <= open_swing_d;
      open_x_q     <= open_x_d;
      open_y_q     <= open_y_d;
      open_z_q     <= open_z_d;
      pend_q       <= pend_d;
    end
  end

`ifndef SYNTHESIS
  a_rel_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.rel_valid |-> pv_q)
    else $error("released a cycle with nothing pending");
  a_rel_needs_swing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.rel_valid |-> phase_q == gcs_pkg::PhSwing)
    else $error("released a cycle outside swing");
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frame_i.final_frame) |=> (!pv_q && phase_q == gcs_pkg::PhSeekFlight))
    else $error("leg state not cleared after the last frame");
`endif

endmodule

// File: rtl/gcs_merge.sv
module gcs_merge (
  input  gcs_pkg::lane_res_t                 left_i,
  input  gcs_pkg::lane_res_t                 right_i,
  output gcs_pkg::out_t                      slot_o [gcs_pkg::MaxResults],
  output logic [gcs_pkg::SlotCntW-1:0]       count_o
);

  gcs_pkg::out_t                   cand [gcs_pkg::MaxResults];
  logic [gcs_pkg::MaxResults-1:0]  cand_valid;

  function automatic gcs_pkg::out_t to_out(logic side, gcs_pkg::cycle_t c);
    gcs_pkg::out_t o;
    o.leg_side     = side;
    o.stance_start = c.stance_start;
    o.swing_start  = c.swing_start;
    o.cycle_end    = c.cycle_end;
    o.start_x      = c.start_x;
    o.start_y      = c.start_y;
    o.start_z      = c.start_z;
    o.end_x        = c.end_x;
    o.end_y        = c.end_y;
    o.end_z        = c.end_z;
    o.last_of_run  = 1'b0;
    return o;
  endfunction

  always_comb begin
    cand[0]    = to_out(gcs_pkg::LegLeft, left_i.rel);
    cand[1]    = to_out(gcs_pkg::LegLeft, left_i.flush);
    cand[2]    = to_out(gcs_pkg::LegRight, right_i.rel);
    cand[3]    = to_out(gcs_pkg::LegRight, right_i.flush);
    cand_valid = {right_i.flush_valid, right_i.rel_valid,
                  left_i.flush_valid, left_i.rel_valid};
  end

  always_comb begin
    logic [gcs_pkg::SlotCntW-1:0] n;
    n = '0;
    for (int s = 0; s < gcs_pkg::MaxResults; s++) begin
      slot_o[s] = cand[s];
    end
    for (int s = 0; s < gcs_pkg::MaxResults; s++) begin
      if (cand_valid[s]) begin
        slot_o[n[gcs_pkg::SlotCntW-2:0]] = cand[s];
        n = n + 1'b1;
      end
    end
    for (int s = 0; s < gcs_pkg::MaxResults; s++) begin
      slot_o[s].last_of_run = (gcs_pkg::SlotCntW'(s) == n - 1'b1);
    end
    count_o = n;
  end

endmodule

// File: rtl/gcs_out_fifo.sv
module gcs_out_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gcs_pkg::out_t                      slot_i [gcs_pkg::MaxResults],
  input  logic [gcs_pkg::SlotCntW-1:0]       push_n_i,
  input  logic                               pop_i,
  output logic                               full_o,
  output logic                               valid_o,
  output gcs_pkg::out_t                      data_o
);

  gcs_pkg::out_t                 mem_q [gcs_pkg::FifoDepth];
  logic [gcs_pkg::PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [gcs_pkg::CntW-1:0]      count_q;

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = count_q > gcs_pkg::CntW'(gcs_pkg::FifoDepth - gcs_pkg::MaxResults);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + gcs_pkg::PtrW'(push_n_i);
      rd_ptr_q <= rd_ptr_q + gcs_pkg::PtrW'(pop_i);
      count_q  <= count_q + gcs_pkg::CntW'(push_n_i) - gcs_pkg::CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < gcs_pkg::MaxResults; s++) begin
      if (gcs_pkg::SlotCntW'(s) < push_n_i) begin
        mem_q[wr_ptr_q + gcs_pkg::PtrW'(s)] <= slot_i[s];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= gcs_pkg::CntW'(gcs_pkg::FifoDepth))
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty result queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i != '0 |-> !full_o)
    else $error("results pushed while the queue lacks room");
`endif

endmodule
